// ===== rtl/mpa_pkg.sv =====
// ============================================================================
// mpa_pkg
// Shared constants, types and register codes of the max pool with argmax block.
// ============================================================================
`default_nettype none

package mpa_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int POS_BITS       = 6;
    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_HEIGHT     = 1024;
    localparam int MAX_SCALE      = 8;
    localparam int PLANE_LIMIT    = 4096;

    localparam int SCALE_BITS     = 4;
    localparam int DIM_BITS       = 11;
    localparam int NP_BITS        = 13;
    localparam int COL_BITS       = 10;
    localparam int OFS_BITS       = 3;
    localparam int PLANE_BITS     = 12;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 13;

    localparam int Q_DEPTH        = 4;
    localparam int Q_PTR_BITS     = 2;
    localparam int Q_CNT_BITS     = 3;

    localparam int RES_DEPTH      = 2;
    localparam int RES_CNT_BITS   = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_SCALE      = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH       = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT      = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PLANES_PER_SAMPLE = 2'd3;

    // One in-window sample, classified by the front end
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] value;
        logic [COL_BITS-1:0]           col;        // window column index
        logic                          first_col;  // kx == 0
        logic                          top_row;    // ky == 0
        logic                          last;       // bottom-right sample
        logic [POS_BITS-1:0]           pos;        // ky*scale+kx
        logic                          plane_done;
        logic                          sample_done;
    } item_t;

    // Running best of one window column
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] value;
        logic [POS_BITS-1:0]           pos;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] max_value;
        logic [POS_BITS-1:0]           max_position;
        logic                          plane_done;
        logic                          sample_done;
    } result_t;

    // Status of the item queue
    typedef struct packed {
        logic full;
        logic valid;
    } qstat_t;

endpackage

`default_nettype wire

// ===== rtl/mpa_ram.sv =====
// ============================================================================
// mpa_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module mpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                                         clk,
    input  wire                                         we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire  [WIDTH-1:0]                            wdata,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/mpa_front.sv =====
// ============================================================================
// mpa_front
// Configuration registers, raster position counters and sample classification.
// ============================================================================
`default_nettype none

module mpa_front (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_we,
    input  wire  [mpa_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire  [mpa_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  wire                                  push,
    input  wire  signed [mpa_pkg::SAMPLE_BITS-1:0] pixel_value,
    input  wire                                  q_full,
    output logic                                 item_push,
    output mpa_pkg::item_t                       item
);

    import mpa_pkg::*;

    logic [SCALE_BITS-1:0] sc_reg, sc_next;
    logic [DIM_BITS-1:0]   w_reg, w_next;
    logic [DIM_BITS-1:0]   h_reg, h_next;
    logic [NP_BITS-1:0]    np_reg, np_next;

    logic [COL_BITS-1:0]   col_cnt_reg, col_cnt_next;
    logic [COL_BITS-1:0]   row_cnt_reg, row_cnt_next;
    logic [OFS_BITS-1:0]   kx_reg, kx_next;
    logic [OFS_BITS-1:0]   ky_reg, ky_next;
    logic [DIM_BITS-1:0]   col_base_reg, col_base_next;
    logic [DIM_BITS-1:0]   row_base_reg, row_base_next;
    logic [COL_BITS-1:0]   xx_reg, xx_next;
    logic [PLANE_BITS-1:0] plane_reg, plane_next;

    logic                  in_fire;
    logic [DIM_BITS:0]     sc_w;
    logic                  col_fit, row_fit, col_last, row_last;
    logic                  kx_wrap, ky_wrap, col_end, row_end, plane_end;
    logic [POS_BITS-1:0]   pos;

    function automatic logic [SCALE_BITS-1:0] clamp_scale(input logic [CFG_DATA_BITS-1:0] d);
        logic [SCALE_BITS-1:0] v;
        v = d[SCALE_BITS-1:0];
        if (v == '0)
            return SCALE_BITS'(1);
        else if (v > SCALE_BITS'(MAX_SCALE))
            return SCALE_BITS'(MAX_SCALE);
        return v;
    endfunction

    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [CFG_DATA_BITS-1:0] d,
                                                      input logic [DIM_BITS-1:0] hi);
        logic [DIM_BITS-1:0] v;
        v = d[DIM_BITS-1:0];
        if (v == '0)
            return DIM_BITS'(1);
        else if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [NP_BITS-1:0] clamp_np(input logic [CFG_DATA_BITS-1:0] d);
        logic [NP_BITS-1:0] v;
        v = d[NP_BITS-1:0];
        if (v == '0)
            return NP_BITS'(1);
        else if (v > NP_BITS'(PLANE_LIMIT))
            return NP_BITS'(PLANE_LIMIT);
        return v;
    endfunction

    assign in_fire = push && !q_full;

    always_comb
    begin
        sc_w      = (DIM_BITS+1)'(sc_reg);
        col_fit   = ({1'b0, col_base_reg} + sc_w) <= {1'b0, w_reg};
        row_fit   = ({1'b0, row_base_reg} + sc_w) <= {1'b0, h_reg};
        col_last  = ({1'b0, col_base_reg} + (sc_w << 1)) > {1'b0, w_reg};
        row_last  = ({1'b0, row_base_reg} + (sc_w << 1)) > {1'b0, h_reg};
        kx_wrap   = (SCALE_BITS'(kx_reg) + SCALE_BITS'(1)) >= sc_reg;
        ky_wrap   = (SCALE_BITS'(ky_reg) + SCALE_BITS'(1)) >= sc_reg;
        col_end   = (DIM_BITS'(col_cnt_reg) + DIM_BITS'(1)) >= w_reg;
        row_end   = (DIM_BITS'(row_cnt_reg) + DIM_BITS'(1)) >= h_reg;
        plane_end = (NP_BITS'(plane_reg) + NP_BITS'(1)) >= np_reg;
        pos       = POS_BITS'(ky_reg) * POS_BITS'(sc_reg) + POS_BITS'(kx_reg);
    end

    always_comb
    begin
        item.value       = pixel_value;
        item.col         = xx_reg;
        item.first_col   = (kx_reg == '0);
        item.top_row     = (ky_reg == '0);
        item.last        = kx_wrap && ky_wrap;
        item.pos         = pos;
        item.plane_done  = col_last && row_last;
        item.sample_done = col_last && row_last &&
                           ((NP_BITS'(plane_reg) + NP_BITS'(1)) == np_reg);
        item_push        = in_fire && col_fit && row_fit;
    end

    // Next state of the configuration registers and the raster position
    always_comb
    begin
        sc_next       = sc_reg;
        w_next        = w_reg;
        h_next        = h_reg;
        np_next       = np_reg;
        col_cnt_next  = col_cnt_reg;
        row_cnt_next  = row_cnt_reg;
        kx_next       = kx_reg;
        ky_next       = ky_reg;
        col_base_next = col_base_reg;
        row_base_next = row_base_reg;
        xx_next       = xx_reg;
        plane_next    = plane_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW_SCALE:      sc_next = clamp_scale(cfg_data);
                REG_FRAME_WIDTH:       w_next  = clamp_dim(cfg_data, DIM_BITS'(MAX_WIDTH));
                REG_FRAME_HEIGHT:      h_next  = clamp_dim(cfg_data, DIM_BITS'(MAX_HEIGHT));
                REG_PLANES_PER_SAMPLE: np_next = clamp_np(cfg_data);
                default:               ;
            endcase
            // any write restarts the stream
            col_cnt_next  = '0;
            row_cnt_next  = '0;
            kx_next       = '0;
            ky_next       = '0;
            col_base_next = '0;
            row_base_next = '0;
            xx_next       = '0;
            plane_next    = '0;
        end
        else if (in_fire)
        begin
            if (col_end)
            begin
                col_cnt_next  = '0;
                kx_next       = '0;
                col_base_next = '0;
                xx_next       = '0;
                if (row_end)
                begin
                    row_cnt_next  = '0;
                    ky_next       = '0;
                    row_base_next = '0;
                    plane_next    = plane_end ? '0 : plane_reg + PLANE_BITS'(1);
                end
                else
                begin
                    row_cnt_next = row_cnt_reg + COL_BITS'(1);
                    if (ky_wrap)
                    begin
                        ky_next       = '0;
                        row_base_next = row_base_reg + DIM_BITS'(sc_reg);
                    end
                    else
                    begin
                        ky_next = ky_reg + OFS_BITS'(1);
                    end
                end
            end
            else
            begin
                col_cnt_next = col_cnt_reg + COL_BITS'(1);
                if (kx_wrap)
                begin
                    kx_next       = '0;
                    col_base_next = col_base_reg + DIM_BITS'(sc_reg);
                    xx_next       = xx_reg + COL_BITS'(1);
                end
                else
                begin
                    kx_next = kx_reg + OFS_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg       <= SCALE_BITS'(2);
            w_reg        <= DIM_BITS'(64);
            h_reg        <= DIM_BITS'(64);
            np_reg       <= NP_BITS'(1);
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            kx_reg       <= '0;
            ky_reg       <= '0;
            col_base_reg <= '0;
            row_base_reg <= '0;
            xx_reg       <= '0;
            plane_reg    <= '0;
        end
        else
        begin
            sc_reg       <= sc_next;
            w_reg        <= w_next;
            h_reg        <= h_next;
            np_reg       <= np_next;
            col_cnt_reg  <= col_cnt_next;
            row_cnt_reg  <= row_cnt_next;
            kx_reg       <= kx_next;
            ky_reg       <= ky_next;
            col_base_reg <= col_base_next;
            row_base_reg <= row_base_next;
            xx_reg       <= xx_next;
            plane_reg    <= plane_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mpa_queue.sv =====
// ============================================================================
// mpa_queue
// Short item queue that decouples classification from the store update.
// ============================================================================
`default_nettype none

module mpa_queue (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             wr_en,
    input  mpa_pkg::item_t  wr_item,
    input  wire             rd_en,
    output mpa_pkg::item_t  rd_item,
    output mpa_pkg::qstat_t stat
);

    import mpa_pkg::*;

    item_t                 mem_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  do_wr, do_rd;

    always_comb
    begin
        stat.full   = (cnt_reg == Q_CNT_BITS'(Q_DEPTH));
        stat.valid  = (cnt_reg != '0);
        do_wr       = wr_en && !stat.full;
        do_rd       = rd_en && stat.valid;
        wr_ptr_next = do_wr ? wr_ptr_reg + Q_PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + Q_PTR_BITS'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + Q_CNT_BITS'(do_wr) - Q_CNT_BITS'(do_rd);
        rd_item     = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mpa_back.sv =====
// ============================================================================
// mpa_back
// Column store read-modify-write, running window best and result buffer.
// ============================================================================
`default_nettype none

module mpa_back (
    input  wire              clk,
    input  wire              rst_n,
    input  mpa_pkg::item_t   q_item,
    input  wire              q_valid,
    output logic             q_pop,
    input  wire              pop,
    output logic             empty,
    output mpa_pkg::result_t res
);

    import mpa_pkg::*;

    // update stage: item waiting for its store read
    logic                  s1_valid_reg, s1_valid_next;
    item_t                 s1_item_reg;
    logic                  byp_hit_reg, byp_hit_next;
    entry_t                byp_data_reg;
    entry_t                cur_reg;

    logic [ENTRY_BITS-1:0] ram_rdata;
    logic [COL_BITS-1:0]   rd_col;
    entry_t                mem_entry, ref_entry, best;
    logic                  s1_proc, res_room, pop_fire, res_push;

    // result buffer
    result_t               res_mem_reg [RES_DEPTH];
    logic                  res_wr_reg, res_rd_reg;
    logic [RES_CNT_BITS-1:0] res_cnt_reg, res_cnt_next;
    result_t               res_in;

    mpa_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_store (
        .clk   (clk),
        .we    (s1_proc),
        .waddr (s1_item_reg.col),
        .wdata (best),
        .raddr (rd_col),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        pop_fire = pop && (res_cnt_reg != '0);
        res_room = (res_cnt_reg != RES_CNT_BITS'(RES_DEPTH)) || pop_fire;
        s1_proc  = s1_valid_reg && res_room;
        q_pop    = q_valid && (!s1_valid_reg || s1_proc);

        // keep reading the held item's column while the update stage stalls
        rd_col = q_pop ? q_item.col : s1_item_reg.col;

        // a write to the same column in the read cycle is missed by the RAM
        mem_entry = byp_hit_reg ? byp_data_reg : entry_t'(ram_rdata);
        ref_entry = s1_item_reg.first_col ? mem_entry : cur_reg;

        if (s1_item_reg.first_col && s1_item_reg.top_row)
        begin
            best.value = s1_item_reg.value;
            best.pos   = '0;
        end
        else if ($signed(s1_item_reg.value) > $signed(ref_entry.value))
        begin
            best.value = s1_item_reg.value;
            best.pos   = s1_item_reg.pos;
        end
        else
        begin
            best = ref_entry;
        end

        byp_hit_next  = s1_proc && (s1_item_reg.col == q_item.col);
        s1_valid_next = q_pop ? 1'b1 : (s1_proc ? 1'b0 : s1_valid_reg);

        res_push             = s1_proc && s1_item_reg.last;
        res_in.max_value     = best.value;
        res_in.max_position  = best.pos;
        res_in.plane_done    = s1_item_reg.plane_done;
        res_in.sample_done   = s1_item_reg.sample_done;
        res_cnt_next         = res_cnt_reg + RES_CNT_BITS'(res_push) -
                               RES_CNT_BITS'(pop_fire);

        empty = (res_cnt_reg == '0);
        res   = res_mem_reg[res_rd_reg];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_item_reg  <= q_item;
            byp_hit_reg  <= byp_hit_next;
            byp_data_reg <= best;
        end
        if (s1_proc)
        begin
            cur_reg <= best;
        end
        if (res_push)
        begin
            res_mem_reg[res_wr_reg] <= res_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            res_wr_reg   <= 1'b0;
            res_rd_reg   <= 1'b0;
            res_cnt_reg  <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            res_cnt_reg  <= res_cnt_next;
            if (res_push)
            begin
                res_wr_reg <= !res_wr_reg;
            end
            if (pop_fire)
            begin
                res_rd_reg <= !res_rd_reg;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/max_pool_with_argmax.sv =====
// ============================================================================
// max_pool_with_argmax
// Streaming 2-D max pooling with argmax over signed Q8.8 feature planes.
// ============================================================================
// Push one sample per cycle in raster order, plane after plane; the block
// sustains one sample per clock while full is low. Square windows of side
// window_scale, stride window_scale, each give one result (maximum, its
// offset ky*scale+kx, and plane/sample end flags) once the bottom-right
// sample has been transferred; the result passes through the item queue and
// the update stage before it appears on the output side. The column store
// is a 1024-entry RAM with registered read that is read and written once
// per sample. Ties keep the first maximum in row-major order. Leftover
// columns and rows are consumed without results. Any configuration write
// restarts the stream at the first sample of plane zero; write only while no
// results are outstanding. No clearing pass follows reset: every store entry
// is written at the top-left of its window before it is read.
// ============================================================================
`default_nettype none

module max_pool_with_argmax (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    cfg_we,
    input  wire  [mpa_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire  [mpa_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    input  wire                                    push,
    output logic                                   full,
    input  wire  signed [mpa_pkg::SAMPLE_BITS-1:0] pixel_value,
    output logic                                   empty,
    input  wire                                    pop,
    output logic signed [mpa_pkg::SAMPLE_BITS-1:0] max_value,
    output logic [mpa_pkg::POS_BITS-1:0]           max_position,
    output logic                                   plane_done,
    output logic                                   sample_done
);

    import mpa_pkg::*;

    item_t   fe_item;
    logic    fe_push;
    item_t   q_item;
    qstat_t  q_stat;
    logic    q_pop;
    result_t res;

    // Front: hold configuration, advance raster counters, drop leftover samples
    mpa_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .pixel_value (pixel_value),
        .q_full      (q_stat.full),
        .item_push   (fe_push),
        .item        (fe_item)
    );

    // Queue: let the front take samples while the back stalls on the output
    mpa_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fe_push),
        .wr_item (fe_item),
        .rd_en   (q_pop),
        .rd_item (q_item),
        .stat    (q_stat)
    );

    // Back: update the column store and emit one result per finished window
    mpa_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_item  (q_item),
        .q_valid (q_stat.valid),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .res     (res)
    );

    assign full         = q_stat.full;
    assign max_value    = res.max_value;
    assign max_position = res.max_position;
    assign plane_done   = res.plane_done;
    assign sample_done  = res.sample_done;

`ifndef NO_ASSERTIONS
    // The last result of a sample is always the last result of its plane
    a_sample_implies_plane: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (!sample_done || plane_done))
        else $error("sample_done without plane_done");

    // A full item queue always presents an item to the back end
    a_queue_full_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> q_stat.valid)
        else $error("item queue full but empty");

    // The back end never draws from an empty item queue
    a_pop_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_stat.valid)
        else $error("item queue read while empty");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ============================================================================
// tb
// Self-checking bench for the streaming max pool with argmax block.
// ============================================================================
// Feeds signed Q8.8 samples through the push/full side and drains window
// results through the empty/pop side. A bit-accurate window predictor follows
// every accepted sample and queues the result it foresees; each popped result
// is checked field by field against the oldest queued one. A short table of
// directed rows comes first, then randomised phases, each with its own
// register settings, mostly whole planes with a few cut-off streams.
// ============================================================================

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mpa_pkg::*;

    localparam int SETTLE_CYCLES = 32;       // input queue, RAM read and result queue
    localparam int RAND_ITEMS    = 1650;
    localparam int LIMIT_CYCLES  = 400_000;
    localparam int REPORT_MAX    = 10;

    // ------------------------------------------------------------------------
    // Clock and DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          cfg_we      = 1'b0;
    logic [CFG_INDEX_BITS-1:0]     cfg_index   = '0;
    logic [CFG_DATA_BITS-1:0]      cfg_data    = '0;
    logic                          push        = 1'b0;
    logic                          full;
    logic signed [SAMPLE_BITS-1:0] pixel_value = '0;
    logic                          empty;
    logic                          pop         = 1'b0;
    logic signed [SAMPLE_BITS-1:0] max_value;
    logic [POS_BITS-1:0]           max_position;
    logic                          plane_done;
    logic                          sample_done;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    max_pool_with_argmax u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .pixel_value  (pixel_value),
        .empty        (empty),
        .pop          (pop),
        .max_value    (max_value),
        .max_position (max_position),
        .plane_done   (plane_done),
        .sample_done  (sample_done)
    );

    // ------------------------------------------------------------------------
    // Window predictor state: its own copy of the registers and counters
    // ------------------------------------------------------------------------
    logic [SCALE_BITS-1:0]         reg_scale;
    logic [DIM_BITS-1:0]           reg_width;
    logic [DIM_BITS-1:0]           reg_height;
    logic [NP_BITS-1:0]            reg_planes;

    logic signed [SAMPLE_BITS-1:0] col_best [MAX_WIDTH];
    logic [POS_BITS-1:0]           col_pos  [MAX_WIDTH];
    int unsigned                   col_cnt;
    int unsigned                   row_cnt;
    int unsigned                   kx_ofs;
    int unsigned                   ky_ofs;
    int unsigned                   plane_idx;
    int unsigned                   pixels_sent = 0;  // samples transferred so far

    result_t                       window_max_q [$];  // foreseen results, oldest first

    int unsigned                   mismatch_cnt = 0;
    result_t                       head_want;

    // Sender burst shaping
    bit                            gaps_on    = 1'b0;
    int unsigned                   burst_left = 0;

    // ------------------------------------------------------------------------
    // Directed table: registers and samples, expected result typed in where
    // it is plain to see, otherwise taken from the predictor
    // ------------------------------------------------------------------------
    typedef enum bit {ROW_PIXEL, ROW_CONFIG} row_kind_e;

    typedef struct {
        row_kind_e                     kind;
        logic [CFG_INDEX_BITS-1:0]     idx;
        logic [CFG_DATA_BITS-1:0]      data;
        logic signed [SAMPLE_BITS-1:0] pix;
        bit                            typed;
        logic signed [SAMPLE_BITS-1:0] want_val;
        logic [POS_BITS-1:0]           want_pos;
        bit                            want_pd;
        bit                            want_sd;
    } dir_row_t;

    localparam int DIR_ROWS = 36;

    dir_row_t dir_tab [DIR_ROWS] = '{
        // one-sample windows on a 4x1 plane, two planes per sample
        '{ROW_CONFIG, REG_WINDOW_SCALE,      13'd1, 16'sh0000, 1'b0, 16'sh0000, 6'd0, 1'b0, 1'b0},
        '{ROW_CONFIG, REG_FRAME_WIDTH,       13'd4, 16'sh0000, 1'b0, 16'sh0000, 6'd0, 1'b0, 1'b0},
        '{ROW_CONFIG, REG_FRAME_HEIGHT,      13'd1, 16'sh0000, 1'b0, 16'sh0000, 6'd0, 1'b0, 1'b0},
        '{ROW_CONFIG, REG_PLANES_PER_SAMPLE, 13'd2, 16'sh0000, 1'b0, 16'sh0000, 6'd0, 1'b0, 1'b0},
        '{ROW_PIXEL,  REG_WINDOW_SCALE,      13'd0, 16'sh8000, 1'b1, 16'sh8000, 6'd0, 1'b0, 1'b0},
        '{ROW_PIXEL,  REG_WINDOW_SCALE,      13'd0, 16'sh7FFF, 1'b1, 16'sh7FFF, 6'd0, 1'b0, 1'b0},
        '{ROW_PIXEL,  REG_WINDOW_SCALE,      13'd0, 16'sh0000, 1'b1, 16'sh0000, 6'd0, 1'b0, 1'b0},
        '{ROW_PIXEL,  REG_WINDOW_SCALE,      13'd0, 16'shFFFF, 1'b1, 16'shFFFF, 6'd0, 1'b1, 1'b0},
        '{ROW_PIXEL,  REG_WINDOW_SCALE,      13'd0, 16'sh0001, 1'b1, 16'sh0001, 6'd0, 1'b0, 1'b0},
        '{ROW_PIXEL,  REG_WINDOW_SCALE,      13'd0, 16'sh5555, 1'b1, 16'sh5555, 6'd0, 1'b0, 1'b0},
        '{ROW_PIXEL,  REG_WINDOW_SCALE,      13'd0, 16'shAAAA, 1'b1, 16'shAAAA, 6'd0, 1'b0, 1'b0},
        '{ROW_PIXEL,  REG_WINDOW_SCALE,      13'd0, 16'sh7FFF, 1'b1, 16'sh7FFF, 6'd0, 1'b1, 1'b1},
        // 2x2 window on a 2x2 plane: a four-way tie keeps the first sample
        '{ROW_CONFIG, REG_WINDOW_SCALE,      13'd2, 16'sh0000, 1'b0, 16'sh0000, 6'd0, 1'b0, 1'b0},
        '{ROW_CONFIG, REG_FRAME_WIDTH,       13'd2, 16'sh0000, 1'b0, 16'sh0000, 6'd0, 1'b0, 1'b0},
        '{ROW_CONFIG, REG_FRAME_HEIGHT,      13'd2, 16'sh0000, 1'b0, 16'sh0000, 6'd0, 1'b0, 1'b0},
        '{ROW_CONFIG, REG_PLANES_PER_SAMPLE, 13'd1, 16'sh0000, 1'b0, 16'sh0000, 6'd0, 1'b0, 1'b0},
        '{ROW_PIXEL,  REG_WINDOW_SCALE,      13'd0, 16'sh0005, 1'b0, 16'sh0000, 6'd0, 1'b0, 1'b0},
        '{ROW_PIXEL,  REG_WINDOW_SCALE,      13'd0, 16'sh0005, 1'b0, 16'sh0000, 6'd0, 1'b0, 1'b0},
        '{ROW_PIXEL,  REG_WINDOW_SCALE,      13'd0, 16'sh0005, 1'b0, 16'sh0000, 6'd0, 1'b0, 1'b0},
        '{ROW_PIXEL,  REG_WINDOW_SCALE,      13'd0, 16'sh0005, 1'b1, 16'sh0005, 6'd0, 1'b1, 1'b1},
        // most negative everywhere but the bottom-right corner
        '{ROW_PIXEL,  REG_WINDOW_SCALE,      13'd0, 16'sh8000, 1'b0, 16'sh0000, 6'd0, 1'b0, 1'b0},
        '{ROW_PIXEL,  REG_WINDOW_SCALE,      13'd0, 16'sh8000, 1'b0, 16'sh0000, 6'd0, 1'b0, 1'b0},
        '{ROW_PIXEL,  REG_WINDOW_SCALE,      13'd0, 16'sh8000, 1'b0, 16'sh0000, 6'd0, 1'b0, 1'b0},
        '{ROW_PIXEL,  REG_WINDOW_SCALE,      13'd0, 16'sh7FFF, 1'b1, 16'sh7FFF, 6'd3, 1'b1, 1'b1},
        // scale of zero behaves as one
        '{ROW_CONFIG, REG_WINDOW_SCALE,      13'd0, 16'sh0000, 1'b0, 16'sh0000, 6'd0, 1'b0, 1'b0},
        '{ROW_PIXEL,  REG_WINDOW_SCALE,      13'd0, 16'sh0007, 1'b1, 16'sh0007, 6'd0, 1'b0, 1'b0},
        '{ROW_PIXEL,  REG_WINDOW_SCALE,      13'd0, 16'shFFF9, 1'b1, 16'shFFF9, 6'd0, 1'b0, 1'b0},
        // scale above the maximum saturates: window wider than the plane
        '{ROW_CONFIG, REG_WINDOW_SCALE,      13'd15, 16'sh0000, 1'b0, 16'sh0000, 6'd0, 1'b0, 1'b0},
        '{ROW_PIXEL,  REG_WINDOW_SCALE,      13'd0, 16'sh0064, 1'b0, 16'sh0000, 6'd0, 1'b0, 1'b0},
        '{ROW_PIXEL,  REG_WINDOW_SCALE,      13'd0, 16'sh00C8, 1'b0, 16'sh0000, 6'd0, 1'b0, 1'b0},
        // zero sizes and zero planes behave as one
        '{ROW_CONFIG, REG_PLANES_PER_SAMPLE, 13'd0, 16'sh0000, 1'b0, 16'sh0000, 6'd0, 1'b0, 1'b0},
        '{ROW_CONFIG, REG_FRAME_WIDTH,       13'd0, 16'sh0000, 1'b0, 16'sh0000, 6'd0, 1'b0, 1'b0},
        '{ROW_CONFIG, REG_FRAME_HEIGHT,      13'd0, 16'sh0000, 1'b0, 16'sh0000, 6'd0, 1'b0, 1'b0},
        '{ROW_CONFIG, REG_WINDOW_SCALE,      13'd1, 16'sh0000, 1'b0, 16'sh0000, 6'd0, 1'b0, 1'b0},
        '{ROW_PIXEL,  REG_WINDOW_SCALE,      13'd0, 16'sh0009, 1'b1, 16'sh0009, 6'd0, 1'b1, 1'b1},
        '{ROW_PIXEL,  REG_WINDOW_SCALE,      13'd0, 16'shFFF7, 1'b1, 16'shFFF7, 6'd0, 1'b1, 1'b1}
    };

    // ------------------------------------------------------------------------
    // Predictor helpers
    // ------------------------------------------------------------------------
    function automatic int unsigned clamp_cfg(input int unsigned v, input int unsigned hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    // Advance the window state by one accepted sample; return 1 with the
    // window maximum when the sample closes a window.
    function automatic bit pool_advance(input logic signed [SAMPLE_BITS-1:0] v,
                                        output result_t res);
        int unsigned sc;
        int unsigned w;
        int unsigned h;
        int unsigned np;
        int unsigned xx;
        int unsigned yy;
        bit          hit;
        sc  = clamp_cfg(reg_scale, MAX_SCALE);
        w   = clamp_cfg(reg_width, MAX_WIDTH);
        h   = clamp_cfg(reg_height, MAX_HEIGHT);
        np  = clamp_cfg(reg_planes, PLANE_LIMIT);
        xx  = col_cnt / sc;
        yy  = row_cnt / sc;
        hit = 1'b0;
        res = '0;
        if (xx < w / sc && yy < h / sc)
        begin
            // Top-left opens the window; later samples win only when strictly greater
            if (kx_ofs == 0 && ky_ofs == 0)
            begin
                col_best[xx] = v;
                col_pos[xx]  = '0;
            end
            else if (v > col_best[xx])
            begin
                col_best[xx] = v;
                col_pos[xx]  = POS_BITS'(ky_ofs * sc + kx_ofs);
            end
            if (kx_ofs == sc - 1 && ky_ofs == sc - 1)
            begin
                hit              = 1'b1;
                res.max_value    = col_best[xx];
                res.max_position = col_pos[xx];
                res.plane_done   = (xx == w / sc - 1) && (yy == h / sc - 1);
                res.sample_done  = res.plane_done && (plane_idx == np - 1);
            end
        end
        col_cnt++;
        kx_ofs = (kx_ofs + 1 >= sc) ? 0 : kx_ofs + 1;
        if (col_cnt >= w)
        begin
            col_cnt = 0;
            kx_ofs  = 0;
            row_cnt++;
            ky_ofs  = (ky_ofs + 1 >= sc) ? 0 : ky_ofs + 1;
            if (row_cnt >= h)
            begin
                row_cnt = 0;
                ky_ofs  = 0;
                plane_idx++;
                if (plane_idx >= np)
                    plane_idx = 0;
            end
        end
        return hit;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------------

    // Write one register; any write restarts the stream at plane zero.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_WINDOW_SCALE:      reg_scale  = val[SCALE_BITS-1:0];
            REG_FRAME_WIDTH:       reg_width  = val[DIM_BITS-1:0];
            REG_FRAME_HEIGHT:      reg_height = val[DIM_BITS-1:0];
            REG_PLANES_PER_SAMPLE: reg_planes = val[NP_BITS-1:0];
            default: ;
        endcase
        col_cnt   = 0;
        row_cnt   = 0;
        kx_ofs    = 0;
        ky_ofs    = 0;
        plane_idx = 0;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold push low, wait for every foreseen result, then let samples that
    // close no window drain out of the pipeline.
    task automatic settle_block();
        @(negedge clk);
        push <= 1'b0;
        while (window_max_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Transfer one sample, inserting a random gap at the end of each burst.
    task automatic send_pixel(input logic signed [SAMPLE_BITS-1:0] v,
                              input bit typed, input result_t want);
        result_t     got;
        int unsigned gap;
        if (gaps_on && burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                push <= 1'b0;
            end
            burst_left = $urandom_range(1, 20);
        end
        @(negedge clk);
        push        <= 1'b1;
        pixel_value <= v;
        do
            @(posedge clk);
        while (full);
        // Transfer taken at this edge: advance the predictor
        pixels_sent++;
        if (pool_advance(v, got) && !typed)
            window_max_q.push_back(got);
        if (typed)
            window_max_q.push_back(want);
        if (burst_left > 0)
            burst_left--;
    endtask

    // Sample mix: half full-range, some near-ties, some extremes.
    function automatic logic signed [SAMPLE_BITS-1:0] next_pixel();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return SAMPLE_BITS'($urandom);
        else if (pick < 8)
            return SAMPLE_BITS'($urandom_range(0, 4)) - 16'sd2;
        else if (pick < 9)
            return 16'sh7FFF - SAMPLE_BITS'($urandom_range(0, 1));
        return 16'sh8000 + SAMPLE_BITS'($urandom_range(0, 1));
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: pop on a pattern of its own, changed after each random stretch of cycles
    // ------------------------------------------------------------------------
    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_SLOW} rx_mode_e;

    initial
    begin
        rx_mode_e    rx_mode;
        int unsigned stretch;
        forever
        begin
            rx_mode = rx_mode_e'($urandom_range(0, 2));
            stretch = $urandom_range(16, 64);
            repeat (stretch)
            begin
                @(negedge clk);
                case (rx_mode)
                    RX_ALWAYS: pop <= 1'b1;
                    RX_RANDOM: pop <= ($urandom_range(0, 1) != 0);
                    default:   pop <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each transfer with the oldest foreseen result
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (window_max_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_MAX)
                    $display("%0t: unexpected result value=%0d pos=%0d pd=%0b sd=%0b",
                             $time, max_value, max_position, plane_done, sample_done);
            end
            else
            begin
                head_want = window_max_q.pop_front();
                if (max_value !== head_want.max_value
                    || max_position !== head_want.max_position
                    || plane_done !== head_want.plane_done
                    || sample_done !== head_want.sample_done)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display({"%0t: mismatch exp value=%0d pos=%0d pd=%0b sd=%0b",
                                  " got value=%0d pos=%0d pd=%0b sd=%0b"},
                                 $time, head_want.max_value, head_want.max_position,
                                 head_want.plane_done, head_want.sample_done,
                                 max_value, max_position, plane_done, sample_done);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: drop the run if it stalls well beyond the slowest pass
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        result_t                  want;
        int unsigned              phase_no;
        int unsigned              count;
        int unsigned              ew;
        int unsigned              eh;
        int unsigned              sent_start;
        logic [CFG_DATA_BITS-1:0] c_scale;
        logic [CFG_DATA_BITS-1:0] c_width;
        logic [CFG_DATA_BITS-1:0] c_height;
        logic [CFG_DATA_BITS-1:0] c_planes;

        // Predictor starts from the reset register values
        reg_scale      = SCALE_BITS'(2);
        reg_width      = DIM_BITS'(64);
        reg_height     = DIM_BITS'(64);
        reg_planes     = NP_BITS'(1);
        col_cnt        = 0;
        row_cnt        = 0;
        kx_ofs         = 0;
        ky_ofs         = 0;
        plane_idx      = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table; settle before every register write
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CONFIG)
            begin
                settle_block();
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            end
            else
            begin
                want.max_value    = dir_tab[i].want_val;
                want.max_position = dir_tab[i].want_pos;
                want.plane_done   = dir_tab[i].want_pd;
                want.sample_done  = dir_tab[i].want_sd;
                send_pixel(dir_tab[i].pix, dir_tab[i].typed, want);
            end
        end

        // Random phases: fresh settings each time, extremes at fixed phases
        phase_no   = 0;
        sent_start = pixels_sent;
        while (pixels_sent - sent_start < RAND_ITEMS)
        begin
            settle_block();
            count = 0;
            case (phase_no)
                1:
                begin
                    // widest plane, saturated from the top of the field
                    c_scale  = 13'd1;
                    c_width  = 13'd2047;
                    c_height = 13'd0;
                    c_planes = 13'd1;
                    count    = MAX_WIDTH;
                end
                2:
                begin
                    // tallest plane and most planes, cut off early
                    c_scale  = 13'd1;
                    c_width  = 13'd1;
                    c_height = 13'd2047;
                    c_planes = 13'd8191;
                    count    = 60;
                end
                3:
                begin
                    c_scale  = 13'd2;
                    c_width  = 13'd4;
                    c_height = 13'd2;
                    c_planes = 13'd4096;
                    count    = 24;
                end
                4:
                begin
                    // largest window: offsets up to 63
                    c_scale  = 13'd8;
                    c_width  = 13'd8;
                    c_height = 13'd8;
                    c_planes = 13'd1;
                    count    = 64;
                end
                default:
                begin
                    // upper bits above the scale, width and height register widths are random junk
                    c_scale = {9'($urandom), 4'(($urandom_range(0, 9) < 7)
                                                ? $urandom_range(1, 4)
                                                : $urandom_range(0, 15))};
                    c_width = {2'($urandom), 11'(($urandom_range(0, 7) != 0)
                                                 ? $urandom_range(1, 12)
                                                 : $urandom_range(0, 20))};
                    c_height = {2'($urandom), 11'(($urandom_range(0, 7) != 0)
                                                  ? $urandom_range(1, 12)
                                                  : $urandom_range(0, 20))};
                    c_planes = 13'(($urandom_range(0, 9) != 0) ? $urandom_range(1, 3) : 0);
                end
            endcase
            write_reg(REG_WINDOW_SCALE, c_scale);
            write_reg(REG_FRAME_WIDTH, c_width);
            write_reg(REG_FRAME_HEIGHT, c_height);
            write_reg(REG_PLANES_PER_SAMPLE, c_planes);

            ew = clamp_cfg(c_width[DIM_BITS-1:0], MAX_WIDTH);
            eh = clamp_cfg(c_height[DIM_BITS-1:0], MAX_HEIGHT);
            if (count == 0)
            begin
                // mostly whole planes; otherwise a stream broken mid-plane
                if ($urandom_range(0, 4) != 0)
                    count = ew * eh * ((ew * eh > 100) ? 1 : $urandom_range(1, 3));
                else
                    count = $urandom_range(1, 2 * ew * eh);
            end
            // keep the random part close to its item budget
            if (count > RAND_ITEMS - (pixels_sent - sent_start))
                count = RAND_ITEMS - (pixels_sent - sent_start);

            gaps_on    = ($urandom_range(0, 3) != 0);
            burst_left = 0;
            repeat (count)
                send_pixel(next_pixel(), 1'b0, '0);
            phase_no++;
        end

        settle_block();
        if (mismatch_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
